>>> hw/rtl/psra_pkg.sv
`timescale 1ns / 1ps

package psra_pkg;

	// Fixed sizes of the arbiter.
	localparam int NUM_TARGETS  = 16;
	localparam int NUM_CONTROLS = 16;

	localparam int TGT_W      = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
	localparam int TARGET_W   = 4;
	localparam int IDX_W      = 4;
	localparam int TYPE_W     = 3;
	localparam int UTIL_W     = 11;
	localparam int MAP_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [UTIL_W-1:0] util_t;
	typedef logic [TGT_W-1:0]  tgt_t;

	// Request type codes.
	localparam logic [TYPE_W-1:0] REQ_LIMIT     = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_UNLIMIT   = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_COMMIT    = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_CLEAR_TGT = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_CLEAR_ALL = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_MAP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOB_THR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UTIL_THRESH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LU_READ,
		ST_LU_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_C_DECIDE,
		ST_FINISH
	} state_t;

	// True when the control index exists on the device.
	function automatic logic ctrl_in_range(input idx_t i);
		return (int'(i) < NUM_CONTROLS);
	endfunction

endpackage

>>> hw/rtl/psra_if.sv
`timescale 1ns / 1ps

interface psra_req_if;
	import psra_pkg::*;

	logic                valid;
	logic                ready;
	logic [TYPE_W-1:0]   req_type;
	logic [TARGET_W-1:0] target;
	idx_t                current_index;
	util_t               utilization;

	modport source(output valid, req_type, target, current_index, utilization, input ready);
	modport sink(input valid, req_type, target, current_index, utilization, output ready);
endinterface

interface psra_res_if;
	import psra_pkg::*;

	logic valid;
	logic ready;
	logic done_res;
	logic set_control;
	idx_t control_index;

	modport source(output valid, done_res, set_control, control_index, input ready);
	modport sink(input valid, done_res, set_control, control_index, output ready);
endinterface

>>> hw/rtl/psra_ram.sv
`timescale 1ns / 1ps

module psra_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/perf_state_request_arbiter.sv
`timescale 1ns / 1ps

// Performance-state request arbiter for one P-state or T-state knob. Each of the
// sixteen targets may hold one requested control index (smaller index means more
// performance); the levels live in a small RAM and a flip-flop valid bit per target
// marks which ones are live, so reset clears all requests at once. Items arrive as
// beats on the req channel and every item yields exactly one result beat on rsp.
// The block takes one item at a time and is not ready until that item's result is
// in the output register; the output register lets it take the next item while the
// previous result still waits. Timing is set by the single read port of the level
// RAM: a commit walks all sixteen slots one per cycle through a shared compare unit,
// then drains the last RAM read in a drain state and does the clamping and the P/T
// transition rules in a decide state before the next accept. Limit and unlimit read
// their own slot and then decide; clears, refused requests and unused request types
// go straight to a finish state. A stalled result port stretches any of these until
// the output register is free. Configuration writes on the cfg port take effect at
// the next clock edge and are meant for idle time.
module perf_state_request_arbiter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psra_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psra_pkg::CFG_DATA_W-1:0]     cfg_data,
	psra_req_if.sink                            req,
	psra_res_if.source                          rsp
);
	import psra_pkg::*;

	// Configuration registers.
	idx_t             upper_q;
	idx_t             lower_q;
	logic [MAP_W-1:0] thr_map_q;
	logic             knob_thr_q;
	util_t            thresh_q;
	logic             supported_q;

	// Item being worked on.
	state_t            state_q, state_d;
	logic [TYPE_W-1:0] type_q;
	logic [TARGET_W-1:0] tgt_q;
	idx_t              cur_q;
	util_t             util_q;

	// Request store: valid bits in flops, levels in RAM.
	logic [NUM_TARGETS-1:0] valid_q;
	logic                   ram_we;
	logic                   ram_re;
	tgt_t                   ram_raddr;
	idx_t                   ram_rdata;

	// Commit scan.
	tgt_t cnt_q;
	logic pipe_vld_s1;
	tgt_t pipe_idx_s1;
	logic any_q;
	idx_t max_q;

	// Result register.
	logic res_valid_q;
	logic res_done_q;
	logic res_set_q;
	idx_t res_idx_q;

	logic accept;
	logic out_free;
	logic res_load;
	logic res_done_d;
	logic res_set_d;
	idx_t res_idx_d;
	logic tgt_ok;
	tgt_t tgt_i;

	// Limit/unlimit decision.
	idx_t eff_lvl;
	idx_t lu_c;
	idx_t lu_nxt;
	logic lu_step_ok;
	logic lu_ok;

	// Commit decision.
	idx_t cand;
	idx_t clamp_lo;
	idx_t c_nxt;
	logic cur_thr;
	logic nxt_thr;
	logic util_ok;
	logic trans_ok;
	logic c_ok;

	assign accept   = req.valid && req.ready;
	assign out_free = !res_valid_q || rsp.ready;
	assign tgt_ok   = (int'(tgt_q) < NUM_TARGETS);
	assign tgt_i    = TGT_W'(tgt_q);

	// ---------------------------------------------------------------------
	// Configuration port. Writes to indexes beyond the register list are dropped.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q     <= '0;
			lower_q     <= IDX_W'(15);
			thr_map_q   <= '0;
			knob_thr_q  <= 1'b0;
			thresh_q    <= '0;
			supported_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UPPER_LIMIT: upper_q     <= cfg_data[IDX_W-1:0];
				CFG_LOWER_LIMIT: lower_q     <= cfg_data[IDX_W-1:0];
				CFG_THR_MAP:     thr_map_q   <= cfg_data[MAP_W-1:0];
				CFG_KNOB_THR:    knob_thr_q  <= cfg_data[0];
				CFG_UTIL_THRESH: thresh_q    <= cfg_data[UTIL_W-1:0];
				CFG_SUPPORTED:   supported_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Limit and unlimit: the target's effective request moves one step, but
	// only inside the bounds and only onto a control of this knob's kind.
	// ---------------------------------------------------------------------
	always_comb begin
		eff_lvl    = valid_q[tgt_i] ? ram_rdata : upper_q;
		lu_c       = eff_lvl;
		lu_nxt     = eff_lvl;
		lu_step_ok = 1'b0;
		if (type_q == REQ_LIMIT) begin
			if (lu_c < upper_q) begin
				lu_c = upper_q;
			end
			lu_step_ok = (lu_c < lower_q);
			lu_nxt     = lu_c + IDX_W'(1);
		end else begin
			if (lu_c > lower_q) begin
				lu_c = lower_q;
			end
			lu_step_ok = (lu_c > upper_q);
			lu_nxt     = lu_c - IDX_W'(1);
		end
		lu_ok = lu_step_ok && ctrl_in_range(lu_nxt) && (thr_map_q[lu_nxt] == knob_thr_q);
	end

	// ---------------------------------------------------------------------
	// Commit: clamp the scanned maximum (or the current index) and apply the
	// P/T transition rules.
	// ---------------------------------------------------------------------
	always_comb begin
		cand     = any_q ? max_q : cur_q;
		clamp_lo = (cand > lower_q) ? lower_q : cand;
		c_nxt    = (clamp_lo < upper_q) ? upper_q : clamp_lo;
		cur_thr  = thr_map_q[cur_q];
		nxt_thr  = thr_map_q[c_nxt];
		util_ok  = (util_q >= thresh_q);
		case ({cur_thr, nxt_thr})
			2'b00:   trans_ok = !knob_thr_q;
			2'b01:   trans_ok = !knob_thr_q && util_ok;
			2'b11:   trans_ok = knob_thr_q && ((c_nxt > cur_q) ? util_ok : 1'b1);
			default: trans_ok = knob_thr_q;
		endcase
		c_ok = (c_nxt != cur_q) && ctrl_in_range(cur_q) && ctrl_in_range(c_nxt) && trans_ok;
	end

	// ---------------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = tgt_i;
		ram_we     = 1'b0;
		res_load   = 1'b0;
		res_done_d = 1'b0;
		res_set_d  = 1'b0;
		res_idx_d  = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if ((req.req_type == REQ_LIMIT || req.req_type == REQ_UNLIMIT) &&
					    supported_q && (int'(req.target) < NUM_TARGETS)) begin
						state_d = ST_LU_READ;
					end else if (req.req_type == REQ_COMMIT && supported_q) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_LU_READ: begin
				ram_re  = 1'b1;
				state_d = ST_LU_DECIDE;
			end
			ST_LU_DECIDE: begin
				if (out_free) begin
					res_load   = 1'b1;
					ram_we     = lu_ok;
					res_done_d = lu_ok;
					res_idx_d  = lu_ok ? lu_nxt : '0;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_q;
				if (int'(cnt_q) == NUM_TARGETS - 1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_C_DECIDE;
			end
			ST_C_DECIDE: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_done_d = c_ok;
					res_set_d  = c_ok;
					res_idx_d  = c_ok ? c_nxt : '0;
					state_d    = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Item capture; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			tgt_q  <= req.target;
			cur_q  <= req.current_index;
			util_q <= req.utilization;
		end
	end

	// Valid bits: clears act as the item is accepted, a successful limit or
	// unlimit marks its target as it writes the level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && req.req_type == REQ_CLEAR_ALL) begin
			valid_q <= '0;
		end else if (accept && req.req_type == REQ_CLEAR_TGT &&
		             (int'(req.target) < NUM_TARGETS)) begin
			valid_q[TGT_W'(req.target)] <= 1'b0;
		end else if (ram_we && tgt_ok) begin
			valid_q[tgt_i] <= 1'b1;
		end
	end

	psra_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NUM_TARGETS)
	) u_level_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tgt_i),
		.wdata(lu_nxt),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Commit scan: one slot address per cycle, the compare unit folds the
	// returned level into the running maximum in the cycle after.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pipe_vld_s1 <= 1'b0;
			any_q       <= 1'b0;
		end else begin
			pipe_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				cnt_q <= '0;
				any_q <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) begin
					cnt_q <= cnt_q + TGT_W'(1);
				end
				if (pipe_vld_s1 && valid_q[pipe_idx_s1]) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pipe_idx_s1 <= cnt_q;
		if (accept) begin
			max_q <= '0;
		end else if (pipe_vld_s1 && valid_q[pipe_idx_s1] && (ram_rdata > max_q)) begin
			max_q <= ram_rdata;
		end
	end

	// ---------------------------------------------------------------------
	// Result register.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_done_q <= res_done_d;
			res_set_q  <= res_set_d;
			res_idx_q  <= res_idx_d;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.done_res      = res_done_q;
	assign rsp.set_control   = res_set_q;
	assign rsp.control_index = res_idx_q;

	// ---------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------

	// A refused or plain item must come out all zero.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.done_res) |-> (!rsp.set_control && rsp.control_index == '0))
		else $error("refused result carries a nonzero set or index");

	// The last scanned level has been folded in before the commit decides.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C_DECIDE) |-> !pipe_vld_s1)
		else $error("commit decided with a scan read still in flight");

	// Clear-all leaves no request behind.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_CLEAR_ALL) |=> (valid_q == '0))
		else $error("request left valid after clear-all");

endmodule

>>> tb/sv/psra_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the arbiter, keeps its own copy of the request
// store and the configuration, and checks every result beat in order.
module psra_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psra_pkg::CFG_DATA_W-1:0] cfg_data,
	psra_req_if                             req,
	psra_res_if                             rsp,
	output int                              mismatches,
	output int                              pending
);
	import psra_pkg::*;

	typedef struct packed {
		logic done;
		logic issue;
		idx_t ctrl;
	} outcome_t;

	idx_t             upper_idx;
	idx_t             lower_idx;
	logic [MAP_W-1:0] thr_map;
	logic             knob_thr;
	util_t            util_thresh;
	logic             supported;

	logic req_live  [NUM_TARGETS];
	idx_t req_level [NUM_TARGETS];

	outcome_t awaited_outcomes[$];
	int       beats_seen;
	int       mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic note_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("[%0t] MISMATCH beat %0d: %s", $time, beats_seen, msg);
		mismatch_count++;
	endtask

	function automatic logic is_t_state(input int unsigned i);
		if (i >= MAP_W)
			return 1'b0;
		return thr_map[i];
	endfunction

	// P/T transition rules for moving the device from cur to nxt.
	function automatic logic move_allowed(input int unsigned cur, input int unsigned nxt,
			input util_t u);
		logic ct;
		logic nt;
		ct = is_t_state(cur);
		nt = is_t_state(nxt);
		if (!ct && !nt)
			return !knob_thr;
		if (!ct && nt)
			return !knob_thr && (u >= util_thresh);
		if (ct && nt) begin
			if (!knob_thr)
				return 1'b0;
			return (nxt > cur) ? (u >= util_thresh) : 1'b1;
		end
		return knob_thr;
	endfunction

	// Applies one request to the local store and returns what the block must answer.
	function automatic outcome_t arbitrate(input logic [TYPE_W-1:0] kind,
			input logic [TARGET_W-1:0] tgt, input idx_t cur, input util_t u);
		outcome_t    o;
		int unsigned c;
		int unsigned nxt;
		logic        any_live;
		o = '0;
		case (kind)
			REQ_LIMIT, REQ_UNLIMIT: begin
				if (supported && tgt < NUM_TARGETS) begin
					c = req_live[tgt] ? req_level[tgt] : upper_idx;
					if (kind == REQ_LIMIT) begin
						if (c < upper_idx)
							c = upper_idx;
						if (c < lower_idx) begin
							nxt = c + 1;
							if (nxt < NUM_CONTROLS && is_t_state(nxt) == knob_thr) begin
								req_live[tgt]  = 1'b1;
								req_level[tgt] = nxt[IDX_W-1:0];
								o.done = 1'b1;
								o.ctrl = nxt[IDX_W-1:0];
							end
						end
					end else begin
						if (c > lower_idx)
							c = lower_idx;
						if (c > upper_idx) begin
							nxt = c - 1;
							if (nxt < NUM_CONTROLS && is_t_state(nxt) == knob_thr) begin
								req_live[tgt]  = 1'b1;
								req_level[tgt] = nxt[IDX_W-1:0];
								o.done = 1'b1;
								o.ctrl = nxt[IDX_W-1:0];
							end
						end
					end
				end
			end
			REQ_COMMIT: begin
				if (supported) begin
					any_live = 1'b0;
					nxt = 0;
					for (int i = 0; i < NUM_TARGETS; i++) begin
						if (req_live[i]) begin
							any_live = 1'b1;
							if (req_level[i] > nxt)
								nxt = req_level[i];
						end
					end
					if (!any_live)
						nxt = cur;
					if (nxt > lower_idx)
						nxt = lower_idx;
					if (nxt < upper_idx)
						nxt = upper_idx;
					if (nxt != cur && cur < NUM_CONTROLS && nxt < NUM_CONTROLS &&
							move_allowed(cur, nxt, u)) begin
						o.done  = 1'b1;
						o.issue = 1'b1;
						o.ctrl  = nxt[IDX_W-1:0];
					end
				end
			end
			REQ_CLEAR_TGT: begin
				if (tgt < NUM_TARGETS)
					req_live[tgt] = 1'b0;
			end
			REQ_CLEAR_ALL: begin
				for (int i = 0; i < NUM_TARGETS; i++)
					req_live[i] = 1'b0;
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			upper_idx   = '0;
			lower_idx   = 4'd15;
			thr_map     = '0;
			knob_thr    = 1'b0;
			util_thresh = '0;
			supported   = 1'b1;
			for (int i = 0; i < NUM_TARGETS; i++) begin
				req_live[i]  = 1'b0;
				req_level[i] = '0;
			end
			awaited_outcomes.delete();
			beats_seen = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_UPPER_LIMIT: upper_idx   = cfg_data[IDX_W-1:0];
					CFG_LOWER_LIMIT: lower_idx   = cfg_data[IDX_W-1:0];
					CFG_THR_MAP:     thr_map     = cfg_data[MAP_W-1:0];
					CFG_KNOB_THR:    knob_thr    = cfg_data[0];
					CFG_UTIL_THRESH: util_thresh = cfg_data[UTIL_W-1:0];
					CFG_SUPPORTED:   supported   = cfg_data[0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					note_mismatch("result beat with no request outstanding");
				end else begin
					want = awaited_outcomes.pop_front();
					if (rsp.done_res !== want.done)
						note_mismatch($sformatf("done_res %b, want %b", rsp.done_res, want.done));
					if (rsp.set_control !== want.issue)
						note_mismatch($sformatf("set_control %b, want %b",
							rsp.set_control, want.issue));
					if (rsp.control_index !== want.ctrl)
						note_mismatch($sformatf("control_index %0d, want %0d",
							rsp.control_index, want.ctrl));
				end
				beats_seen++;
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(arbitrate(req.req_type, req.target,
					req.current_index, req.utilization));
			pending <= awaited_outcomes.size();
		end
	end

endmodule

>>> tb/sv/tb_perf_state_request_arbiter.sv
`timescale 1ns / 1ps

// Top of the arbiter testbench. This module only creates stimulus and gives the
// verdict; all prediction and comparison happens in psra_checker, which sits
// beside the block and watches the same channels.
module tb_perf_state_request_arbiter;
	import psra_pkg::*;

	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES   = 16;
	localparam int LONG_HOLD       = 160;
	localparam int SETTLE_CYCLES   = 25;
	localparam int CYCLE_LIMIT     = 400000;
	// Request type codes past the last defined one; the block must ignore them.
	localparam int SPARE_FIRST = int'(REQ_CLEAR_ALL) + 1;
	localparam int SPARE_LAST  = (1 << TYPE_W) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int n_mismatch;
	int n_pending;
	int cycle_count = 0;

	// Stimulus-side knobs. tx_relaxed turns off the sender's random gaps for a
	// stretch; lim_weight tilts limit against unlimit so levels drift far; the
	// stall counters let the stimulus ask the receiver for one long hold-off.
	logic  tx_relaxed = 1'b0;
	int    lim_weight = 40;
	util_t thr_now = '0;
	int    stall_asks = 0;
	int    stall_grants = 0;

	psra_req_if req_ch ();
	psra_res_if rsp_ch ();

	perf_state_request_arbiter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	psra_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.mismatches(n_mismatch),
		.pending   (n_pending)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one request beat. The sender first idles for a random gap (unless a
	// no-idle stretch is active), then holds valid until the block takes the beat.
	// It returns on the accepting edge, so a following call with no gap keeps
	// valid high without dropping it in between.
	task automatic offer(input logic [TYPE_W-1:0] kind, input logic [TARGET_W-1:0] tgt,
			input idx_t cur, input util_t util);
		int gap;
		gap = tx_relaxed ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.target        <= tgt;
		req_ch.current_index <= cur;
		req_ch.utilization   <= util;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stops offering and waits until every predicted result beat has been seen.
	// Every request yields exactly one result, so an empty prediction queue also
	// means the block itself has gone idle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
	endtask

	// Rewrites all six configuration registers, one per cycle, while the block is
	// idle. cfg_we stays high across the burst and drops once at the end.
	task automatic program_regs(input idx_t up, input idx_t lo, input logic [MAP_W-1:0] map,
			input logic knob, input util_t thr, input logic sup);
		drain();
		thr_now   = thr;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_UPPER_LIMIT;
		cfg_data  <= {12'd0, up};
		@(posedge clk);
		cfg_index <= CFG_LOWER_LIMIT;
		cfg_data  <= {12'd0, lo};
		@(posedge clk);
		cfg_index <= CFG_THR_MAP;
		cfg_data  <= map;
		@(posedge clk);
		cfg_index <= CFG_KNOB_THR;
		cfg_data  <= {15'd0, knob};
		@(posedge clk);
		cfg_index <= CFG_UTIL_THRESH;
		cfg_data  <= {5'd0, thr};
		@(posedge clk);
		cfg_index <= CFG_SUPPORTED;
		cfg_data  <= {15'd0, sup};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random request. Most traffic is limit and unlimit on a handful of
	// targets, so their levels walk all the way between the bounds before a
	// commit looks at them; clears and spare codes are sprinkled in as noise.
	// Utilization favors the threshold and its neighbor below, where the
	// T-state entry check flips. counted is low for beats the block ignores.
	task automatic random_item(output bit counted);
		int                  r;
		logic [TYPE_W-1:0]   kind;
		logic [TARGET_W-1:0] tgt;
		idx_t                cur;
		util_t               util;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < lim_weight)
			kind = REQ_LIMIT;
		else if (r < 68)
			kind = REQ_UNLIMIT;
		else if (r < 88)
			kind = REQ_COMMIT;
		else if (r < 94)
			kind = REQ_CLEAR_TGT;
		else if (r < 96)
			kind = REQ_CLEAR_ALL;
		else begin
			kind = TYPE_W'($urandom_range(SPARE_FIRST, SPARE_LAST));
			counted = 1'b0;
		end
		tgt = TARGET_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) :
			$urandom_range(0, 15));
		cur = IDX_W'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0: util = '0;
			1: util = 11'd1024;
			2: util = thr_now;
			3: util = (thr_now == 0) ? thr_now : thr_now - 1'b1;
			default: util = UTIL_W'($urandom_range(0, 1024));
		endcase
		offer(kind, tgt, cur, util);
	endtask

	// Receiver. For every result beat it draws a random wait with ready low, then
	// raises ready until a beat goes through. Every sixteen beats it may switch to a
	// stretch with no waiting at all. When the stimulus asks for it, it also holds
	// ready low for a long counted stretch so the block's output register fills and
	// the request side backs up.
	initial begin
		int   wait_cycles;
		int   hold_left;
		int   rx_count;
		logic rx_relaxed;
		rsp_ch.ready = 1'b0;
		rx_count = 0;
		rx_relaxed = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_count % 16 == 0)
				rx_relaxed = ($urandom_range(0, 3) == 0);
			if (stall_grants != stall_asks) begin
				rsp_ch.ready <= 1'b0;
				hold_left = LONG_HOLD;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
				stall_grants++;
			end
			wait_cycles = rx_relaxed ? 0 : $urandom_range(0, 19);
			if (wait_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			rx_count++;
		end
	end

	// Main stimulus: reset, a short directed pass over the special cases, then
	// random phases that each start from a fresh configuration.
	initial begin
		bit               counted;
		int               n_in_phase;
		idx_t             up;
		idx_t             lo;
		idx_t             swap;
		logic [MAP_W-1:0] map;
		util_t            thr;
		logic             knob;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_LIMIT;
		req_ch.target        = '0;
		req_ch.current_index = '0;
		req_ch.utilization   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, written explicitly. A commit with nothing requested keeps
		// the device where it is; limit and unlimit walk one step and stop at the
		// upper bound; commit follows the slowest (largest) request.
		program_regs(4'd0, 4'd15, 16'h0000, 1'b0, 11'd0, 1'b1);
		offer(REQ_COMMIT, 4'd0, 4'd15, 11'd1024);
		offer(REQ_LIMIT, 4'd0, 4'd0, 11'd0);
		offer(REQ_LIMIT, 4'd15, 4'd15, 11'd1023);
		offer(REQ_UNLIMIT, 4'd0, 4'd0, 11'd0);
		offer(REQ_UNLIMIT, 4'd0, 4'd0, 11'd0);
		offer(REQ_COMMIT, 4'd0, 4'd0, 11'd0);
		offer(REQ_CLEAR_TGT, 4'd15, 4'd0, 11'd0);
		offer(REQ_COMMIT, 4'd5, 4'd0, 11'd1024);
		for (int k = SPARE_FIRST; k <= SPARE_LAST; k++)
			offer(TYPE_W'(k), 4'd15, 4'd15, 11'd1024);

		// Crossed bounds: limit is refused and commit lands on the upper bound.
		program_regs(4'd10, 4'd4, 16'hFFFF, 1'b1, 11'd1024, 1'b1);
		offer(REQ_LIMIT, 4'd3, 4'd9, 11'd1024);
		offer(REQ_COMMIT, 4'd3, 4'd15, 11'd1024);

		// P knob, T-states from index 8 up. Clamping to the upper bound pushes a
		// commit from a P-state into a T-state, which needs enough utilization.
		// A limit into the T range is refused for a P knob.
		program_regs(4'd9, 4'd12, 16'hFF00, 1'b0, 11'd512, 1'b1);
		offer(REQ_CLEAR_ALL, 4'd0, 4'd0, 11'd0);
		offer(REQ_COMMIT, 4'd0, 4'd3, 11'd511);
		offer(REQ_COMMIT, 4'd0, 4'd3, 11'd512);
		offer(REQ_LIMIT, 4'd2, 4'd9, 11'd0);

		// T knob: moving to a larger T index needs the utilization check, moving
		// to a smaller one does not.
		program_regs(4'd9, 4'd12, 16'hFF00, 1'b1, 11'd512, 1'b1);
		offer(REQ_LIMIT, 4'd2, 4'd9, 11'd0);
		offer(REQ_COMMIT, 4'd0, 4'd9, 11'd0);
		offer(REQ_COMMIT, 4'd0, 4'd9, 11'd1024);
		offer(REQ_COMMIT, 4'd0, 4'd15, 11'd0);

		// T knob dropping back from a T-state into a P-state.
		program_regs(4'd0, 4'd7, 16'hFF00, 1'b1, 11'd512, 1'b1);
		offer(REQ_CLEAR_ALL, 4'd0, 4'd0, 11'd0);
		offer(REQ_COMMIT, 4'd0, 4'd14, 11'd0);

		// No controls present: limit and commit answer zeros, clears still act.
		program_regs(4'd0, 4'd15, 16'h0000, 1'b0, 11'd0, 1'b0);
		offer(REQ_LIMIT, 4'd4, 4'd0, 11'd0);
		offer(REQ_COMMIT, 4'd4, 4'd15, 11'd1024);
		offer(REQ_CLEAR_ALL, 4'd0, 4'd0, 11'd0);

		// Random phases. Requests are deliberately kept across configuration
		// changes, since a level set under one throttle map can be of the other
		// kind under the next, which is how commit reaches the cross-kind rules.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			up = IDX_W'($urandom_range(0, 15));
			lo = IDX_W'($urandom_range(0, 15));
			if (up > lo && $urandom_range(0, 6) != 0) begin
				swap = up;
				up = lo;
				lo = swap;
			end
			case ($urandom_range(0, 4))
				0: map = '0;
				1: map = '1;
				2: map = 16'hFFFF << $urandom_range(1, 15);
				3: map = MAP_W'($urandom_range(0, 16'hFFFF));
				default: map = ~(16'hFFFF << $urandom_range(1, 15));
			endcase
			case ($urandom_range(0, 3))
				0: thr = '0;
				1: thr = 11'd1024;
				default: thr = UTIL_W'($urandom_range(0, 1024));
			endcase
			knob = 1'($urandom_range(0, 1));
			program_regs(up, lo, map, knob, thr, $urandom_range(0, 9) != 0);
			lim_weight = $urandom_range(20, 50);
			n_in_phase = 0;

			// Once, the receiver goes quiet for a long stretch while the sender
			// keeps pushing beats back to back, so the block has to stall its
			// request side.
			if (phase == 2) begin
				stall_asks++;
				tx_relaxed = 1'b1;
				while (n_in_phase < 24) begin
					random_item(counted);
					if (counted)
						n_in_phase++;
				end
			end

			while (n_in_phase < ITEMS_PER_PHASE) begin
				if (n_in_phase % 16 == 0)
					tx_relaxed = ($urandom_range(0, 3) == 0);
				random_item(counted);
				if (counted)
					n_in_phase++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_mismatch == 0 && n_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
